// ===== design/source_text_lexer_defines.svh =====
// Assertion macros shared by the lexer modules.
// Depends on nothing; included by files that assert.
`ifndef SOURCE_TEXT_LEXER_DEFINES_SVH
`define SOURCE_TEXT_LEXER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define STL_ASSERT_IMP(label, clk, rst_n, a, c) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
else $error("assertion failed");
`define STL_ASSERT_NEXT(label, clk, rst_n, a, c) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
else $error("assertion failed");
`else
`define STL_ASSERT_IMP(label, clk, rst_n, a, c)
`define STL_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== design/stl_pkg.sv =====
// Types and constants of the source text lexer.
// Depends on nothing.
package stl_pkg;
    localparam logic [5:0] K_DIV = 6'd22;
    localparam logic [5:0] K_IDENT = 6'd12;
    localparam logic [5:0] K_INTLIT = 6'd13;
    localparam logic [5:0] K_FLOATLIT = 6'd14;
    localparam logic [5:0] K_STRLIT = 6'd15;
    localparam logic [5:0] K_BOOLLIT = 6'd16;
    localparam logic [5:0] K_ASSIGN = 6'd17;
    localparam logic [5:0] K_EQUALS = 6'd18;
    localparam logic [5:0] K_PLUS = 6'd19;
    localparam logic [5:0] K_COMMENT = 6'd49;
    localparam logic [5:0] K_UNKNOWN = 6'd50;
    localparam logic [5:0] K_END = 6'd51;
    localparam logic [5:0] K_INVALID = 6'd52;
    localparam logic [5:0] K_INCR = 6'd53;
    localparam logic [5:0] K_PLUSEQ = 6'd54;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_source;
    } byte_item_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] token_line;
        logic [15:0] token_column;
        logic [11:0] token_length;
        logic        run_end;
        logic        stream_done;
    } token_t;

    typedef enum logic [10:0] {
        M_IDLE  = 11'b00000000001,
        M_IDENT = 11'b00000000010,
        M_NUM   = 11'b00000000100,
        M_BADID = 11'b00000001000,
        M_STR   = 11'b00000010000,
        M_LCOM  = 11'b00000100000,
        M_BCOM  = 11'b00001000000,
        M_SLASH = 11'b00010000000,
        M_EQ    = 11'b00100000000,
        M_PLUS  = 11'b01000000000,
        M_HALT  = 11'b10000000000
    } mode_t;

    function automatic logic [5:0] sym_kind(input logic [7:0] b);
        logic [5:0] k;
        begin
            unique case (b)
                8'h2B: k = 6'd19;
                8'h2D: k = 6'd20;
                8'h2A: k = 6'd21;
                8'h2F: k = 6'd22;
                8'h25: k = 6'd23;
                8'h3C: k = 6'd24;
                8'h3E: k = 6'd25;
                8'h21: k = 6'd31;
                8'h26: k = 6'd32;
                8'h7C: k = 6'd33;
                8'h5E: k = 6'd34;
                8'h7E: k = 6'd35;
                8'h28: k = 6'd38;
                8'h29: k = 6'd39;
                8'h7B: k = 6'd40;
                8'h7D: k = 6'd41;
                8'h5B: k = 6'd42;
                8'h5D: k = 6'd43;
                8'h2C: k = 6'd44;
                8'h3B: k = 6'd45;
                8'h3A: k = 6'd46;
                8'h3F: k = 6'd47;
                8'h2E: k = 6'd48;
                default: k = K_UNKNOWN;
            endcase
            return k;
        end
    endfunction

    function automatic logic [5:0] word_kind(input logic [63:0] w, input logic [3:0] n);
        logic [5:0] k;
        begin
            k = K_IDENT;
            priority case (1'b1)
                n == 4'd2 && w[15:0] == "fn": k = 6'd0;
                n == 4'd3 && w[23:0] == "int": k = 6'd1;
                n == 4'd5 && w[39:0] == "float": k = 6'd2;
                n == 4'd6 && w[47:0] == "string": k = 6'd3;
                n == 4'd4 && w[31:0] == "bool": k = 6'd4;
                n == 4'd6 && w[47:0] == "return": k = 6'd5;
                n == 4'd2 && w[15:0] == "if": k = 6'd6;
                n == 4'd4 && w[31:0] == "else": k = 6'd7;
                n == 4'd3 && w[23:0] == "for": k = 6'd8;
                n == 4'd5 && w[39:0] == "while": k = 6'd9;
                n == 4'd5 && w[39:0] == "break": k = 6'd10;
                n == 4'd8 && w == "continue": k = 6'd11;
                n == 4'd4 && w[31:0] == "true": k = K_BOOLLIT;
                n == 4'd5 && w[39:0] == "false": k = K_BOOLLIT;
                default: k = K_IDENT;
            endcase
            return k;
        end
    endfunction
endpackage

// ===== design/stl_if.sv =====
// Valid/ready channel carrying a payload of type T.
// Depends on nothing.
interface stl_if #(parameter type T = logic) (input logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/source_text_lexer.sv =====
// Streaming lexer top level: byte input channel, token output channel.
// Depends on stl_pkg, stl_if, stl_front, stl_back.
// Usage:
// - src carries one source byte and end_of_source per item; tok carries
//   token_kind, token_line, token_column, token_length, run_end, stream_done.
// - A byte yields zero to three tokens; run_end marks the last of a byte.
// - One byte per cycle is accepted while the token queue holds at most one
//   entry; with tok always ready the rate is one byte per cycle
//   except after bytes that give two or more tokens, which drain one per cycle.
// - A token is registered into the queue when its byte is accepted and is offered on tok from there.
// - The queue holds four tokens; when tok stalls, src ready drops once more
//   than one token waits.
// - Reset clears the queue and returns the scanner to line 1, column 1.
// - After a second decimal point no further tokens come for that source, not
//   even the end token; the end-of-source byte returns the scanner to reset.
module source_text_lexer #(
    parameter int LINE_WIDTH = 16,
    parameter int COLUMN_WIDTH = 16,
    parameter int LENGTH_WIDTH = 12
) (
    input logic clk,
    input logic rst_n,
    stl_if.sink src,
    stl_if.source tok
);
    logic push;
    logic [1:0] cnt;
    logic [5:0] k [3];
    logic [LINE_WIDTH-1:0] l [3];
    logic [COLUMN_WIDTH-1:0] c [3];
    logic [LENGTH_WIDTH-1:0] n [3];
    logic [2:0] d;
    logic room;
    logic [LINE_WIDTH-1:0] ol;
    logic [COLUMN_WIDTH-1:0] oc;
    logic [LENGTH_WIDTH-1:0] on;

    stl_front #(.LW(LINE_WIDTH), .CW(COLUMN_WIDTH), .NW(LENGTH_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(src.valid), .in_ready(src.ready),
        .b(src.data.source_byte), .last(src.data.end_of_source), .q_push(push),
        .q_cnt(cnt), .k_o(k), .l_o(l), .c_o(c), .n_o(n), .d_o(d), .q_room(room));

    stl_back #(.LW(LINE_WIDTH), .CW(COLUMN_WIDTH), .NW(LENGTH_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n), .push(push), .cnt(cnt), .k_i(k), .l_i(l), .c_i(c),
        .n_i(n), .d_i(d), .room(room), .o_valid(tok.valid), .o_ready(tok.ready),
        .k_o(tok.data.token_kind), .l_o(ol), .c_o(oc), .n_o(on),
        .e_o(tok.data.run_end), .d_o(tok.data.stream_done));

    assign tok.data.token_line = 16'(ol);
    assign tok.data.token_column = 16'(oc);
    assign tok.data.token_length = 12'(on);
endmodule

// ===== design/stl_front.sv =====
// Front: scans bytes and forms up to three token records per byte.
// Depends on stl_pkg and the assertion macros.
`include "source_text_lexer_defines.svh"
module stl_front #(
    parameter int LW = 16,
    parameter int CW = 16,
    parameter int NW = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    b,
    input  logic          last,
    output logic          q_push,
    output logic [1:0]    q_cnt,
    output logic [5:0]    k_o [3],
    output logic [LW-1:0] l_o [3],
    output logic [CW-1:0] c_o [3],
    output logic [NW-1:0] n_o [3],
    output logic [2:0]    d_o,
    input  logic          q_room
);
    localparam logic [LW-1:0] LTOP = '1;
    localparam logic [CW-1:0] CTOP = '1;
    localparam logic [NW-1:0] NTOP = '1;
    stl_pkg::mode_t mode_reg, mode_next;
    logic [LW-1:0] line_reg, line_next, sline_reg, sline_next;
    logic [CW-1:0] col_reg, col_next, scol_reg, scol_next;
    logic [NW-1:0] len_reg, len_next;
    logic [63:0] word_reg, word_next;
    logic [3:0] wn_reg, wn_next;
    logic dot_reg, dot_next, esc_reg, esc_next, star_reg, star_next;
    logic fire, alpha, digit, word, ws, used;
    logic [1:0] cnt;

    assign in_ready = q_room;
    assign fire = in_valid && q_room;
    assign alpha = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    assign digit = b >= "0" && b <= "9";
    assign word = alpha || digit || b == "_";
    assign ws = b == " " || (b >= 8'd9 && b <= 8'd13);
    assign q_push = fire && cnt != 2'd0;
    assign q_cnt = cnt;

    always_comb
    begin
        mode_next = mode_reg; line_next = line_reg; sline_next = sline_reg;
        col_next = col_reg; scol_next = scol_reg; len_next = len_reg;
        word_next = word_reg; wn_next = wn_reg; dot_next = dot_reg;
        esc_next = esc_reg; star_next = star_reg;
        cnt = 2'd0; used = 1'b0; d_o = 3'b000;
        for (int i = 0; i < 3; i++)
        begin
            k_o[i] = '0; l_o[i] = sline_reg; c_o[i] = scol_reg; n_o[i] = len_reg;
        end
        if (mode_reg != stl_pkg::M_HALT)
        begin
            unique case (mode_reg)
                stl_pkg::M_IDENT:
                    if (word || b[7])
                    begin
                        if (wn_reg < 4'd8)
                        begin
                            word_next = {word_reg[55:0], b}; wn_next = wn_reg + 4'd1;
                        end
                        else
                            wn_next = 4'd9;
                        used = 1'b1;
                    end
                    else
                    begin
                        k_o[0] = stl_pkg::word_kind(word_reg, wn_reg); cnt = 2'd1;
                    end
                stl_pkg::M_NUM:
                    if (digit) used = 1'b1;
                    else if (b == ".")
                    begin
                        used = 1'b1;
                        if (dot_reg)
                        begin
                            k_o[0] = stl_pkg::K_INVALID; d_o[0] = 1'b1; cnt = 2'd1;
                            mode_next = stl_pkg::M_HALT;
                        end
                        else
                            dot_next = 1'b1;
                    end
                    else if (alpha || b == "_")
                    begin
                        used = 1'b1; mode_next = stl_pkg::M_BADID;
                    end
                    else
                    begin
                        k_o[0] = dot_reg ? stl_pkg::K_FLOATLIT : stl_pkg::K_INTLIT;
                        cnt = 2'd1;
                    end
                stl_pkg::M_BADID:
                    if (word) used = 1'b1;
                    else
                    begin
                        k_o[0] = stl_pkg::K_INVALID; cnt = 2'd1;
                    end
                stl_pkg::M_STR:
                begin
                    used = 1'b1;
                    if (esc_reg) esc_next = 1'b0;
                    else if (b == 8'h5C) esc_next = 1'b1;
                    else if (b == 8'h22)
                    begin
                        k_o[0] = stl_pkg::K_STRLIT; cnt = 2'd1;
                        n_o[0] = (len_reg == NTOP) ? NTOP : len_reg + 1'b1;
                        mode_next = stl_pkg::M_IDLE;
                    end
                end
                stl_pkg::M_LCOM:
                    if (b == 8'h0A)
                    begin
                        k_o[0] = stl_pkg::K_COMMENT; cnt = 2'd1;
                    end
                    else used = 1'b1;
                stl_pkg::M_BCOM:
                begin
                    used = 1'b1;
                    if (star_reg && b == "/")
                    begin
                        k_o[0] = stl_pkg::K_COMMENT; cnt = 2'd1;
                        n_o[0] = (len_reg == NTOP) ? NTOP : len_reg + 1'b1;
                        mode_next = stl_pkg::M_IDLE;
                    end
                    else star_next = b == "*";
                end
                stl_pkg::M_SLASH:
                    if (b == "/")
                    begin
                        used = 1'b1; mode_next = stl_pkg::M_LCOM;
                    end
                    else if (b == "*")
                    begin
                        used = 1'b1; mode_next = stl_pkg::M_BCOM; star_next = 1'b0;
                    end
                    else
                    begin
                        k_o[0] = stl_pkg::K_DIV; cnt = 2'd1;
                    end
                stl_pkg::M_EQ:
                    if (b == "=")
                    begin
                        used = 1'b1; k_o[0] = stl_pkg::K_EQUALS; cnt = 2'd1;
                        n_o[0] = (len_reg == NTOP) ? NTOP : len_reg + 1'b1;
                        mode_next = stl_pkg::M_IDLE;
                    end
                    else
                    begin
                        k_o[0] = stl_pkg::K_ASSIGN; cnt = 2'd1;
                    end
                stl_pkg::M_PLUS:
                    if (b == "+" || b == "=")
                    begin
                        used = 1'b1; cnt = 2'd1;
                        k_o[0] = (b == "+") ? stl_pkg::K_INCR : stl_pkg::K_PLUSEQ;
                        n_o[0] = (len_reg == NTOP) ? NTOP : len_reg + 1'b1;
                        mode_next = stl_pkg::M_IDLE;
                    end
                    else
                    begin
                        k_o[0] = stl_pkg::K_PLUS; cnt = 2'd1;
                    end
                default: ;
            endcase
            if (used)
            begin
                if (mode_reg != stl_pkg::M_HALT && !(mode_reg == stl_pkg::M_NUM &&
                    b == "." && dot_reg))
                begin
                    if (len_reg != NTOP) len_next = len_reg + 1'b1;
                    if (mode_reg == stl_pkg::M_BCOM && b == 8'h0A)
                    begin
                        if (line_reg != LTOP) line_next = line_reg + 1'b1;
                        col_next = CW'(1);
                    end
                    else if (col_reg != CTOP) col_next = col_reg + 1'b1;
                end
            end
            else
            begin
                mode_next = stl_pkg::M_IDLE;
                if (ws)
                begin
                    if (b == 8'h0A)
                    begin
                        if (line_reg != LTOP) line_next = line_reg + 1'b1;
                        col_next = CW'(1);
                    end
                    else if (col_reg != CTOP) col_next = col_reg + 1'b1;
                end
                else
                begin
                    sline_next = line_reg; scol_next = col_reg; len_next = NW'(1);
                    if (col_reg != CTOP) col_next = col_reg + 1'b1;
                    if (alpha || b == "_" || b[7])
                    begin
                        mode_next = stl_pkg::M_IDENT; word_next = {56'd0, b}; wn_next = 4'd1;
                    end
                    else if (digit)
                    begin
                        mode_next = stl_pkg::M_NUM; dot_next = 1'b0;
                    end
                    else if (b == 8'h22)
                    begin
                        mode_next = stl_pkg::M_STR; esc_next = 1'b0;
                    end
                    else if (b == "/") mode_next = stl_pkg::M_SLASH;
                    else if (b == "=") mode_next = stl_pkg::M_EQ;
                    else if (b == "+") mode_next = stl_pkg::M_PLUS;
                    else
                    begin
                        k_o[cnt] = stl_pkg::sym_kind(b); l_o[cnt] = line_reg;
                        c_o[cnt] = col_reg; n_o[cnt] = NW'(1); cnt = cnt + 2'd1;
                    end
                end
            end
            if (last && mode_next != stl_pkg::M_HALT)
            begin
                if (mode_next != stl_pkg::M_IDLE)
                begin
                    unique case (mode_next)
                        stl_pkg::M_IDENT: k_o[cnt] = stl_pkg::word_kind(word_next, wn_next);
                        stl_pkg::M_NUM:
                            k_o[cnt] = dot_next ? stl_pkg::K_FLOATLIT : stl_pkg::K_INTLIT;
                        stl_pkg::M_BADID: k_o[cnt] = stl_pkg::K_INVALID;
                        stl_pkg::M_STR: k_o[cnt] = stl_pkg::K_STRLIT;
                        stl_pkg::M_SLASH: k_o[cnt] = stl_pkg::K_DIV;
                        stl_pkg::M_EQ: k_o[cnt] = stl_pkg::K_ASSIGN;
                        stl_pkg::M_PLUS: k_o[cnt] = stl_pkg::K_PLUS;
                        default: k_o[cnt] = stl_pkg::K_COMMENT;
                    endcase
                    l_o[cnt] = sline_next; c_o[cnt] = scol_next; n_o[cnt] = len_next;
                    cnt = cnt + 2'd1;
                end
                k_o[cnt] = stl_pkg::K_END; l_o[cnt] = line_next; c_o[cnt] = col_next;
                n_o[cnt] = '0; d_o[cnt] = 1'b1; cnt = cnt + 2'd1;
            end
        end
        if (last)
        begin
            mode_next = stl_pkg::M_IDLE; line_next = LW'(1); col_next = CW'(1);
            scol_next = '0; sline_next = '0; len_next = '0; word_next = '0; wn_next = '0;
            dot_next = 1'b0; esc_next = 1'b0; star_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= stl_pkg::M_IDLE; line_reg <= LW'(1); col_reg <= CW'(1);
            scol_reg <= '0; sline_reg <= '0; len_reg <= '0; word_reg <= '0; wn_reg <= '0;
            dot_reg <= 1'b0; esc_reg <= 1'b0; star_reg <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next; line_reg <= line_next; col_reg <= col_next;
            scol_reg <= scol_next; sline_reg <= sline_next; len_reg <= len_next;
            word_reg <= word_next; wn_reg <= wn_next; dot_reg <= dot_next;
            esc_reg <= esc_next; star_reg <= star_next;
        end
    end

    `STL_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(mode_reg))
    `STL_ASSERT_IMP(a_line_nz, clk, rst_n, 1'b1, line_reg != '0)
    `STL_ASSERT_NEXT(a_last_idle, clk, rst_n, fire && last, mode_reg == stl_pkg::M_IDLE)
endmodule

// ===== design/stl_back.sv =====
// Back: queue of token groups, drained one token per output item.
// Depends on stl_pkg and the assertion macros.
`include "source_text_lexer_defines.svh"
module stl_back #(
    parameter int LW = 16,
    parameter int CW = 16,
    parameter int NW = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [1:0]    cnt,
    input  logic [5:0]    k_i [3],
    input  logic [LW-1:0] l_i [3],
    input  logic [CW-1:0] c_i [3],
    input  logic [NW-1:0] n_i [3],
    input  logic [2:0]    d_i,
    output logic          room,
    output logic          o_valid,
    input  logic          o_ready,
    output logic [5:0]    k_o,
    output logic [LW-1:0] l_o,
    output logic [CW-1:0] c_o,
    output logic [NW-1:0] n_o,
    output logic          e_o,
    output logic          d_o
);
    localparam int W = 6 + LW + CW + NW + 2;
    logic [W-1:0] q_reg [4];
    logic [2:0] cnt_reg;
    logic [1:0] rd_reg, wr_reg;
    logic pop;
    logic [W-1:0] head;

    assign room = cnt_reg <= 3'd1;
    assign o_valid = cnt_reg != 3'd0;
    assign pop = o_valid && o_ready;
    assign head = q_reg[rd_reg];
    assign {k_o, l_o, c_o, n_o, e_o, d_o} = head;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) < cnt)
                    q_reg[wr_reg + 2'(i)] <= {k_i[i], l_i[i], c_i[i], n_i[i],
                        2'(i) == cnt - 2'd1, d_i[i]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0; rd_reg <= '0; wr_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + cnt;
            if (pop) rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_reg + (push ? {1'b0, cnt} : 3'd0) - {2'b0, pop};
        end
    end

    `STL_ASSERT_IMP(a_room, clk, rst_n, push, cnt_reg <= 3'd1)
    `STL_ASSERT_IMP(a_cap, clk, rst_n, 1'b1, cnt_reg <= 3'd4)
    `STL_ASSERT_NEXT(a_hold, clk, rst_n, o_valid && !o_ready && !push, o_valid)
endmodule
